>>> hdl/fltw_pkg.sv
package fltw_pkg;

   localparam logic [1:0] OP_TRANSLATE = 2'd0;
   localparam logic [1:0] OP_MAP       = 2'd1;
   localparam logic [1:0] OP_UNMAP     = 2'd2;
   localparam logic [1:0] OP_RAW       = 2'd3;

   localparam logic [2:0] ST_OK         = 3'd0;
   localparam logic [2:0] ST_NOT_MAPPED = 3'd1;
   localparam logic [2:0] ST_MISALIGNED = 3'd2;
   localparam logic [2:0] ST_POOL_EMPTY = 3'd3;
   localparam logic [2:0] ST_OUTSIDE    = 3'd4;

   localparam logic [1:0] REG_ROOT       = 2'd0;
   localparam logic [1:0] REG_BASE       = 2'd1;
   localparam logic [1:0] REG_POOL_FIRST = 2'd2;
   localparam logic [1:0] REG_POOL_LAST  = 2'd3;

   localparam logic [1:0] AD_WALK  = 2'd0;
   localparam logic [1:0] AD_RAW   = 2'd1;
   localparam logic [1:0] AD_CLEAR = 2'd2;
   localparam logic [1:0] AD_INIT  = 2'd3;

   localparam logic [2:0] WD_ZERO   = 3'd0;
   localparam logic [2:0] WD_RAW    = 3'd1;
   localparam logic [2:0] WD_NEWTAB = 3'd2;
   localparam logic [2:0] WD_USER   = 3'd3;
   localparam logic [2:0] WD_LEAF   = 3'd4;

   localparam logic [1:0] RA_ZERO  = 2'd0;
   localparam logic [1:0] RA_XLATE = 2'd1;
   localparam logic [1:0] RA_UNMAP = 2'd2;

   typedef struct packed {
      logic [5:0]  root_table_frame;
      logic [39:0] store_base_page;
      logic [5:0]  pool_first_frame;
      logic [5:0]  pool_last_frame;
   } cfg_type;

   typedef struct packed {
      logic       load_req;
      logic       set_frame_root;
      logic       set_frame_entry;
      logic       set_frame_next;
      logic       take_frame;
      logic       cnt_clear;
      logic       cnt_inc;
      logic       mem_rd;
      logic       mem_wr;
      logic [1:0] addr_sel;
      logic [2:0] wd_sel;
      logic [1:0] level;
      logic       res_load;
      logic [2:0] res_status;
      logic [1:0] res_addr_sel;
   } cmd_type;

   typedef struct packed {
      logic [1:0] op;
      logic       misaligned;
      logic       raw_outside;
      logic       root_outside;
      logic       present;
      logic       ent_ok;
      logic       need_user;
      logic       pool_ok;
      logic       clr_last;
      logic       init_last;
   } sts_type;

endpackage

>>> hdl/fltw_csr.sv
module fltw_csr
   import fltw_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [4:0]  paddr,
   input  logic [63:0] pwdata,
   output logic [63:0] prdata,
   output logic        pready,
   output cfg_type     cfg
);

   cfg_type cfg_ff, cfg_in;
   logic    wr_en;

   assign wr_en  = psel & penable & pwrite;
   assign pready = 1'b1;
   assign cfg    = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (paddr[4:3])
            REG_ROOT:       cfg_in.root_table_frame = pwdata[5:0];
            REG_BASE:       cfg_in.store_base_page  = pwdata[39:0];
            REG_POOL_FIRST: cfg_in.pool_first_frame = pwdata[5:0];
            REG_POOL_LAST:  cfg_in.pool_last_frame  = pwdata[5:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[4:3])
         REG_ROOT:       prdata = {58'd0, cfg_ff.root_table_frame};
         REG_BASE:       prdata = {24'd0, cfg_ff.store_base_page};
         REG_POOL_FIRST: prdata = {58'd0, cfg_ff.pool_first_frame};
         REG_POOL_LAST:  prdata = {58'd0, cfg_ff.pool_last_frame};
         default:        prdata = 64'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.root_table_frame <= 6'd0;
         cfg_ff.store_base_page  <= 40'd0;
         cfg_ff.pool_first_frame <= 6'd1;
         cfg_ff.pool_last_frame  <= 6'd63;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

>>> hdl/fltw_datapath.sv
module fltw_datapath
   import fltw_pkg::*;
#(
   parameter int TABLE_FRAMES = 64
)
(
   input  logic        clock,
   input  logic        reset,
   input  cfg_type     cfg,
   input  cmd_type     cmd,
   output sts_type     sts,
   input  logic [1:0]  req_opcode,
   input  logic [47:0] req_virtual_address,
   input  logic [51:0] req_physical_address,
   input  logic [11:0] req_entry_flags,
   input  logic [5:0]  req_raw_frame,
   input  logic [8:0]  req_raw_slot,
   input  logic [63:0] req_raw_value,
   output logic [51:0] rsp_result_address,
   output logic [2:0]  rsp_status
);

   localparam int FW    = $clog2(TABLE_FRAMES);
   localparam int AW    = FW + 9;
   localparam int DEPTH = TABLE_FRAMES * 512;
   localparam logic [40:0] FRAMES_LIM = 41'(TABLE_FRAMES);
   localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

   logic [63:0] mem [DEPTH];

   logic [1:0]    op_ff;
   logic [47:0]   va_ff;
   logic [51:0]   pa_ff;
   logic [11:0]   flags_ff;
   logic [5:0]    rframe_ff;
   logic [8:0]    rslot_ff;
   logic [63:0]   rvalue_ff;
   logic [FW-1:0] frame_ff, frame_in;
   logic [6:0]    taken_ff, taken_in;
   logic [AW-1:0] cnt_ff, cnt_in;
   logic [63:0]   rdata_ff;
   logic [51:0]   res_addr_ff, res_addr_in;
   logic [2:0]    res_status_ff;

   logic [AW-1:0] addr;
   logic [63:0]   wdata;
   logic [8:0]    slot;
   logic [39:0]   rel;
   logic [7:0]    next;
   logic [12:0]   root_ext, next_ext, raw_ext;
   logic [FW-1:0] root_frame, next_frame, ent_frame, raw_frame;
   logic [39:0]   new_page;

   assign rel        = rdata_ff[51:12] - cfg.store_base_page;
   assign next       = 8'(cfg.pool_first_frame) + 8'(taken_ff);
   assign root_ext   = 13'(cfg.root_table_frame);
   assign next_ext   = 13'(next);
   assign raw_ext    = 13'(rframe_ff);
   assign root_frame = root_ext[FW-1:0];
   assign next_frame = next_ext[FW-1:0];
   assign raw_frame  = raw_ext[FW-1:0];
   assign ent_frame  = rel[FW-1:0];
   assign new_page   = cfg.store_base_page + 40'(next);

   always_comb begin
      case (cmd.level)
         2'd0:    slot = va_ff[20:12];
         2'd1:    slot = va_ff[29:21];
         2'd2:    slot = va_ff[38:30];
         default: slot = va_ff[47:39];
      endcase
   end

   always_comb begin
      unique case (cmd.addr_sel)
         AD_WALK:  addr = {frame_ff, slot};
         AD_RAW:   addr = {raw_frame, rslot_ff};
         AD_CLEAR: addr = {frame_ff, cnt_ff[8:0]};
         AD_INIT:  addr = cnt_ff;
         default:  addr = cnt_ff;
      endcase
   end

   always_comb begin
      unique case (cmd.wd_sel)
         WD_ZERO:   wdata = 64'd0;
         WD_RAW:    wdata = rvalue_ff;
         WD_NEWTAB: wdata = {12'd0, new_page, 9'd0, flags_ff[2], 2'b11};
         WD_USER:   wdata = rdata_ff | 64'd4;
         WD_LEAF:   wdata = {12'd0, pa_ff[51:12], flags_ff};
         default:   wdata = 64'd0;
      endcase
   end

   assign sts.op           = op_ff;
   assign sts.misaligned   = (va_ff[11:0] != 12'd0) || (pa_ff[11:0] != 12'd0);
   assign sts.raw_outside  = {35'd0, rframe_ff} >= FRAMES_LIM;
   assign sts.root_outside = {35'd0, cfg.root_table_frame} >= FRAMES_LIM;
   assign sts.present      = rdata_ff[0];
   assign sts.ent_ok       = {1'b0, rel} < FRAMES_LIM;
   assign sts.need_user    = flags_ff[2] & ~rdata_ff[2];
   assign sts.pool_ok      = (next <= 8'(cfg.pool_last_frame)) &&
                             ({33'd0, next} < FRAMES_LIM);
   assign sts.clr_last     = cnt_ff[8:0] == 9'h1FF;
   assign sts.init_last    = cnt_ff == LAST_ADDR;

   always_comb begin
      frame_in = frame_ff;
      if (cmd.set_frame_root) begin
         frame_in = root_frame;
      end else if (cmd.set_frame_entry) begin
         frame_in = ent_frame;
      end else if (cmd.set_frame_next) begin
         frame_in = next_frame;
      end
   end

   always_comb begin
      taken_in = taken_ff;
      if (cmd.take_frame) begin
         taken_in = taken_ff + 7'd1;
      end
   end

   always_comb begin
      cnt_in = cnt_ff;
      if (cmd.cnt_clear) begin
         cnt_in = '0;
      end else if (cmd.cnt_inc) begin
         cnt_in = cnt_ff + AW'(1);
      end
   end

   always_comb begin
      case (cmd.res_addr_sel)
         RA_XLATE: res_addr_in = {rdata_ff[51:12], va_ff[11:0]};
         RA_UNMAP: res_addr_in = {rdata_ff[51:12], 12'd0};
         default:  res_addr_in = 52'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         taken_ff <= 7'd0;
         cnt_ff   <= '0;
      end else begin
         taken_ff <= taken_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      frame_ff <= frame_in;
      if (cmd.load_req) begin
         op_ff     <= req_opcode;
         va_ff     <= req_virtual_address;
         pa_ff     <= req_physical_address;
         flags_ff  <= req_entry_flags;
         rframe_ff <= req_raw_frame;
         rslot_ff  <= req_raw_slot;
         rvalue_ff <= req_raw_value;
      end
      if (cmd.res_load) begin
         res_addr_ff   <= res_addr_in;
         res_status_ff <= cmd.res_status;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.mem_wr) begin
         mem[addr] <= wdata;
      end
      if (cmd.mem_rd) begin
         rdata_ff <= mem[addr];
      end
   end

   assign rsp_result_address = res_addr_ff;
   assign rsp_status         = res_status_ff;

endmodule

>>> hdl/fltw_ctrl.sv
module fltw_ctrl
   import fltw_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   output logic    rsp_valid,
   input  sts_type sts,
   output cmd_type cmd
);

   localparam logic [2:0] S_INIT   = 3'd0;
   localparam logic [2:0] S_IDLE   = 3'd1;
   localparam logic [2:0] S_DECODE = 3'd2;
   localparam logic [2:0] S_READ   = 3'd3;
   localparam logic [2:0] S_EVAL   = 3'd4;
   localparam logic [2:0] S_CLEAR  = 3'd5;

   logic [2:0] state_ff, state_in;
   logic [1:0] level_ff, level_in;
   logic       valid_ff, valid_in;
   logic       fin;
   logic [2:0] fin_status;
   logic [1:0] fin_addr;

   always_comb begin
      cmd        = '0;
      cmd.level  = level_ff;
      state_in   = state_ff;
      level_in   = level_ff;
      fin        = 1'b0;
      fin_status = ST_OK;
      fin_addr   = RA_ZERO;
      unique case (state_ff)
         S_INIT: begin
            cmd.mem_wr   = 1'b1;
            cmd.addr_sel = AD_INIT;
            cmd.wd_sel   = WD_ZERO;
            cmd.cnt_inc  = 1'b1;
            if (sts.init_last) begin
               cmd.cnt_clear = 1'b1;
               state_in      = S_IDLE;
            end
         end
         S_IDLE: begin
            if (start) begin
               cmd.load_req = 1'b1;
               state_in     = S_DECODE;
            end
         end
         S_DECODE: begin
            if (sts.op == OP_RAW) begin
               fin = 1'b1;
               if (sts.raw_outside) begin
                  fin_status = ST_OUTSIDE;
               end else begin
                  cmd.mem_wr   = 1'b1;
                  cmd.addr_sel = AD_RAW;
                  cmd.wd_sel   = WD_RAW;
               end
            end else if (sts.op == OP_MAP && sts.misaligned) begin
               fin        = 1'b1;
               fin_status = ST_MISALIGNED;
            end else if (sts.root_outside) begin
               fin        = 1'b1;
               fin_status = ST_OUTSIDE;
            end else begin
               cmd.set_frame_root = 1'b1;
               level_in           = 2'd3;
               state_in           = S_READ;
            end
         end
         S_READ: begin
            cmd.addr_sel = AD_WALK;
            if (sts.op == OP_MAP && level_ff == 2'd0) begin
               cmd.mem_wr = 1'b1;
               cmd.wd_sel = WD_LEAF;
               fin        = 1'b1;
            end else begin
               cmd.mem_rd = 1'b1;
               state_in   = S_EVAL;
            end
         end
         S_EVAL: begin
            cmd.addr_sel = AD_WALK;
            if (level_ff == 2'd0) begin
               fin = 1'b1;
               if (sts.op == OP_UNMAP) begin
                  cmd.mem_wr = 1'b1;
                  cmd.wd_sel = WD_ZERO;
                  fin_addr   = RA_UNMAP;
               end else begin
                  fin_addr = RA_XLATE;
               end
            end else if (sts.op == OP_MAP && !sts.present) begin
               if (!sts.pool_ok) begin
                  fin        = 1'b1;
                  fin_status = ST_POOL_EMPTY;
               end else begin
                  cmd.mem_wr         = 1'b1;
                  cmd.wd_sel         = WD_NEWTAB;
                  cmd.take_frame     = 1'b1;
                  cmd.set_frame_next = 1'b1;
                  cmd.cnt_clear      = 1'b1;
                  state_in           = S_CLEAR;
               end
            end else if (!sts.present) begin
               fin        = 1'b1;
               fin_status = ST_NOT_MAPPED;
            end else begin
               if (sts.op == OP_MAP && sts.need_user) begin
                  cmd.mem_wr = 1'b1;
                  cmd.wd_sel = WD_USER;
               end
               if (!sts.ent_ok) begin
                  fin        = 1'b1;
                  fin_status = ST_OUTSIDE;
               end else begin
                  cmd.set_frame_entry = 1'b1;
                  level_in            = level_ff - 2'd1;
                  state_in            = S_READ;
               end
            end
         end
         S_CLEAR: begin
            cmd.mem_wr   = 1'b1;
            cmd.addr_sel = AD_CLEAR;
            cmd.wd_sel   = WD_ZERO;
            cmd.cnt_inc  = 1'b1;
            if (sts.clr_last) begin
               cmd.cnt_clear = 1'b1;
               level_in      = level_ff - 2'd1;
               state_in      = S_READ;
            end
         end
         default: state_in = S_IDLE;
      endcase
      if (fin) begin
         cmd.res_load     = 1'b1;
         cmd.res_status   = fin_status;
         cmd.res_addr_sel = fin_addr;
         state_in         = S_IDLE;
      end
      valid_in = fin;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
         level_ff <= 2'd0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         level_ff <= level_in;
         valid_ff <= valid_in;
      end
   end

   assign busy      = state_ff != S_IDLE;
   assign rsp_valid = valid_ff;

endmodule

>>> hdl/four_level_page_table_walker.sv
// Four-level page table walker with an on-chip table store.
// A request item is taken when start is high and busy is low; its fields are
// sampled on that edge. One result item follows on rsp_result_address and
// rsp_status, shown for exactly one cycle with rsp_valid high. The receiver
// cannot stall, so the result must be taken in that cycle.
// The single-port table memory sets the pace: a request passes a decode
// state, then a read and an evaluate state per table level. A raw write, a
// misaligned map or a root outside the store ends in the decode state; a map
// writes its leaf in the last read state and clears each new table that it
// adds, all 512 entries, one entry per cycle. A new item may be started in
// the cycle the result is shown.
// After reset the block sweeps the whole store of TABLE_FRAMES * 512 entries
// to zero, one entry per cycle, with busy high. Configuration writes through the
// APB port are taken at any time and must be made only while the block is idle.
module four_level_page_table_walker
   import fltw_pkg::*;
#(
   parameter int TABLE_FRAMES = 64
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_opcode,
   input  logic [47:0] req_virtual_address,
   input  logic [51:0] req_physical_address,
   input  logic [11:0] req_entry_flags,
   input  logic [5:0]  req_raw_frame,
   input  logic [8:0]  req_raw_slot,
   input  logic [63:0] req_raw_value,
   output logic        rsp_valid,
   output logic [51:0] rsp_result_address,
   output logic [2:0]  rsp_status,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [4:0]  paddr,
   input  logic [63:0] pwdata,
   output logic [63:0] prdata,
   output logic        pready
);

   cfg_type cfg;
   cmd_type cmd;
   sts_type sts;

   fltw_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   fltw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .sts       (sts),
      .cmd       (cmd)
   );

   fltw_datapath #(
      .TABLE_FRAMES (TABLE_FRAMES)
   ) u_datapath (
      .clock                (clock),
      .reset                (reset),
      .cfg                  (cfg),
      .cmd                  (cmd),
      .sts                  (sts),
      .req_opcode           (req_opcode),
      .req_virtual_address  (req_virtual_address),
      .req_physical_address (req_physical_address),
      .req_entry_flags      (req_entry_flags),
      .req_raw_frame        (req_raw_frame),
      .req_raw_slot         (req_raw_slot),
      .req_raw_value        (req_raw_value),
      .rsp_result_address   (rsp_result_address),
      .rsp_status           (rsp_status)
   );

endmodule

>>> hdl/fltw_checker.sv
module fltw_checker
   import fltw_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       start,
   input logic       busy,
   input logic       rsp_valid,
   input logic [2:0] rsp_status
);

   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held longer than one cycle");

   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result shown while busy");

   a_strobe_after_work: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result shown without work before it");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted item did not make the block busy");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == ST_OK || rsp_status == ST_NOT_MAPPED ||
                     rsp_status == ST_MISALIGNED || rsp_status == ST_POOL_EMPTY ||
                     rsp_status == ST_OUTSIDE))
      else $error("result status out of range");

endmodule

bind four_level_page_table_walker fltw_checker u_fltw_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .rsp_valid  (rsp_valid),
   .rsp_status (rsp_status)
);
